>>> design/wrsd_pkg.sv
// ----------------------------------------------------------------------------
// wrsd_pkg
// Shared widths, register indexes, reset values and interface structs of the
// windowed RMS silence detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wrsd_pkg;

  localparam int WINDOW_SIZE_BITS = 14;
  localparam int THRESHOLD_BITS   = 31;
  localparam int MIN_RUN_BITS     = 32;
  localparam int OUT_BITS         = 32;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_SQ = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_RUN      = 2'd2;

  localparam logic [WINDOW_SIZE_BITS-1:0] WINDOW_SIZE_RESET  = 14'd2400;
  localparam logic [THRESHOLD_BITS-1:0]   THRESHOLD_SQ_RESET = 31'd1073742;
  localparam logic [MIN_RUN_BITS-1:0]     MIN_RUN_RESET      = 32'd4800;

  typedef struct packed {
    logic open;    // sample starts a new window
    logic close;   // sample ends the window
    logic silent;  // closed window is below threshold
  } win_status_t;

  typedef struct packed {
    logic                valid;
    logic [OUT_BITS-1:0] start;
    logic [OUT_BITS-1:0] stop;
  } run_report_t;

endpackage

`default_nettype wire

>>> design/wrsd_window.sv
// ----------------------------------------------------------------------------
// wrsd_window
// Squares each sample, accumulates window energy with saturation, counts
// samples and decides at window close whether the window is silent.
// ----------------------------------------------------------------------------
`default_nettype none

module wrsd_window #(
  parameter int SAMPLE_BITS = 16,
  parameter int WINDOW_BITS = 13
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       step,
  input  wire logic                                       first,
  input  wire logic                                       last,
  input  wire logic signed [SAMPLE_BITS-1:0]              sample,
  input  wire logic [wrsd_pkg::WINDOW_SIZE_BITS-1:0]      window_size,
  input  wire logic [wrsd_pkg::THRESHOLD_BITS-1:0]        threshold_sq,
  output wrsd_pkg::win_status_t                           status
);

  localparam int ENERGY_BITS = 2 * SAMPLE_BITS - 2 + WINDOW_BITS;
  localparam int CNT_BITS    = WINDOW_BITS + 1;
  localparam int WS_BITS     = wrsd_pkg::WINDOW_SIZE_BITS;
  localparam int WSX_BITS    = (CNT_BITS > WS_BITS) ? CNT_BITS : WS_BITS;
  localparam int PROD_BITS   = wrsd_pkg::THRESHOLD_BITS + CNT_BITS;
  localparam int CMP_BITS    = (PROD_BITS > ENERGY_BITS) ? PROD_BITS : ENERGY_BITS;
  localparam logic [WSX_BITS-1:0] WIN_MAX = WSX_BITS'(1) << WINDOW_BITS;

  logic [ENERGY_BITS-1:0]   energy_sum;
  logic [CNT_BITS-1:0]      window_count;

  logic [ENERGY_BITS-1:0]   energy_cur;
  logic [CNT_BITS-1:0]      cnt_cur;
  logic [CNT_BITS-1:0]      cnt_new;
  logic [SAMPLE_BITS-1:0]   sample_u;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic [ENERGY_BITS:0]     sum_wide;
  logic [ENERGY_BITS-1:0]   sum_sat;
  logic [WSX_BITS-1:0]      ws_ext;
  logic [WSX_BITS-1:0]      win_x;
  logic [CNT_BITS-1:0]      win;
  logic [PROD_BITS-1:0]     product;

  assign energy_cur = first ? '0 : energy_sum;
  assign cnt_cur    = first ? '0 : window_count;
  assign cnt_new    = cnt_cur + CNT_BITS'(1);

  assign sample_u = sample;
  assign mag      = sample_u[SAMPLE_BITS-1] ? (~sample_u + SAMPLE_BITS'(1)) : sample_u;
  assign sq       = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
  assign sum_wide = {1'b0, energy_cur} + (ENERGY_BITS+1)'(sq);
  assign sum_sat  = sum_wide[ENERGY_BITS] ? '1 : sum_wide[ENERGY_BITS-1:0];

  // zero means one sample, oversize clamps to the largest window
  assign ws_ext = WSX_BITS'(window_size);
  assign win_x  = (ws_ext == '0) ? WSX_BITS'(1) : ((ws_ext > WIN_MAX) ? WIN_MAX : ws_ext);
  assign win    = CNT_BITS'(win_x);

  assign product = PROD_BITS'(threshold_sq) * PROD_BITS'(cnt_new);

  assign status.open   = (cnt_cur == '0);
  assign status.close  = (cnt_new >= win) || last;
  assign status.silent = CMP_BITS'(sum_sat) < CMP_BITS'(product);

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum   <= '0;
      window_count <= '0;
    end else if (step) begin
      if (status.close) begin
        energy_sum   <= '0;
        window_count <= '0;
      end else begin
        energy_sum   <= sum_sat;
        window_count <= cnt_new;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    WSX_BITS'(window_count) <= WIN_MAX)
    else $error("window count beyond largest window");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    step && status.close |=> window_count == '0 && energy_sum == '0)
    else $error("window not cleared after close");

endmodule

`default_nettype wire

>>> design/wrsd_run.sv
// ----------------------------------------------------------------------------
// wrsd_run
// Tracks the clip position, window starts and the current silent run, and
// reports runs longer than the minimum when a loud window or clip end ends them.
// ----------------------------------------------------------------------------
`default_nettype none

module wrsd_run #(
  parameter int INDEX_BITS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  step,
  input  wire logic                                  first,
  input  wire logic                                  last,
  input  wire wrsd_pkg::win_status_t                 status,
  input  wire logic [wrsd_pkg::MIN_RUN_BITS-1:0]     min_run_samples,
  output wrsd_pkg::run_report_t                      report
);

  localparam int MR_BITS   = wrsd_pkg::MIN_RUN_BITS;
  localparam int DIFF_BITS = (INDEX_BITS > MR_BITS) ? INDEX_BITS : MR_BITS;
  localparam int OB        = wrsd_pkg::OUT_BITS;

  logic [INDEX_BITS-1:0] position;
  logic [INDEX_BITS-1:0] window_begin;
  logic [INDEX_BITS-1:0] silence_begin;
  logic                  in_silence;

  logic [INDEX_BITS-1:0] pos_cur;
  logic [INDEX_BITS-1:0] wbeg_cur;
  logic [INDEX_BITS-1:0] sbeg_cur;
  logic                  insil_cur;
  logic [INDEX_BITS-1:0] wbeg_eff;
  logic [INDEX_BITS-1:0] pos_new;
  logic [INDEX_BITS-1:0] sbeg_next;
  logic                  insil_next;
  logic [INDEX_BITS-1:0] len_close;
  logic [INDEX_BITS-1:0] len_end;

  assign pos_cur   = first ? '0 : position;
  assign wbeg_cur  = first ? '0 : window_begin;
  assign sbeg_cur  = first ? '0 : silence_begin;
  assign insil_cur = first ? 1'b0 : in_silence;
  assign wbeg_eff  = status.open ? pos_cur : wbeg_cur;
  assign pos_new   = (pos_cur == '1) ? pos_cur : (pos_cur + INDEX_BITS'(1));
  assign len_close = wbeg_eff - sbeg_cur;
  assign len_end   = pos_new - sbeg_next;

  always_comb begin
    sbeg_next    = sbeg_cur;
    insil_next   = insil_cur;
    report.valid = 1'b0;
    report.start = OB'(sbeg_cur);
    report.stop  = OB'(wbeg_eff);
    if (status.close) begin
      if (status.silent) begin
        if (!insil_cur) begin
          sbeg_next  = wbeg_eff;
          insil_next = 1'b1;
        end
      end else if (insil_cur) begin
        if (DIFF_BITS'(len_close) > DIFF_BITS'(min_run_samples)) begin
          report.valid = 1'b1;
        end
        insil_next = 1'b0;
      end
    end
    if (last && insil_next && (DIFF_BITS'(len_end) > DIFF_BITS'(min_run_samples))) begin
      report.valid = 1'b1;
      report.start = OB'(sbeg_next);
      report.stop  = OB'(pos_new);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      window_begin  <= '0;
      silence_begin <= '0;
      in_silence    <= 1'b0;
    end else if (step) begin
      if (last) begin
        position      <= '0;
        window_begin  <= '0;
        silence_begin <= '0;
        in_silence    <= 1'b0;
      end else begin
        position      <= pos_new;
        window_begin  <= wbeg_eff;
        silence_begin <= sbeg_next;
        in_silence    <= insil_next;
      end
    end
  end

  a_clip_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && last |=> position == '0 && !in_silence)
    else $error("state not cleared at clip end");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    in_silence |-> silence_begin <= window_begin)
    else $error("silent run starts after current window");

endmodule

`default_nettype wire

>>> design/windowed_rms_silence_detector.sv
// ----------------------------------------------------------------------------
// windowed_rms_silence_detector
// Finds silent runs in a sample stream by windowed energy against a threshold.
// ----------------------------------------------------------------------------
// Takes one word per clock, unless in_stall is high, into an input register;
// from there it squares the sample, updates the window energy and run state
// and loads any reported run into the result register. It sustains one
// sample per cycle while out_stall is low. The energy accumulate and the
// threshold-times-count product, both computed between the input register and
// the state registers, set the clock. clip_first clears all state; after a
// clip_last word the next word starts a fresh clip at index 0. Configuration
// is always ready and should be written while no word is in flight.
`default_nettype none

module windowed_rms_silence_detector #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 32,
  parameter int WINDOW_BITS = 13
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample,
  input  wire logic                                   clip_first,
  input  wire logic                                   clip_last,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [wrsd_pkg::OUT_BITS-1:0]               run_start,
  output logic [wrsd_pkg::OUT_BITS-1:0]               run_end,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [wrsd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [wrsd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  logic [wrsd_pkg::WINDOW_SIZE_BITS-1:0] window_size;
  logic [wrsd_pkg::THRESHOLD_BITS-1:0]   threshold_sq;
  logic [wrsd_pkg::MIN_RUN_BITS-1:0]     min_run_samples;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_first;
  logic                          s1_last;

  logic                          out_free;
  logic                          step;
  logic                          accept;
  wrsd_pkg::win_status_t         status;
  wrsd_pkg::run_report_t         report;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign step      = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size     <= wrsd_pkg::WINDOW_SIZE_RESET;
      threshold_sq    <= wrsd_pkg::THRESHOLD_SQ_RESET;
      min_run_samples <= wrsd_pkg::MIN_RUN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wrsd_pkg::REG_WINDOW_SIZE: begin
          window_size <= wrsd_pkg::WINDOW_SIZE_BITS'(cfg_data);
        end
        wrsd_pkg::REG_THRESHOLD_SQ: begin
          threshold_sq <= wrsd_pkg::THRESHOLD_BITS'(cfg_data);
        end
        wrsd_pkg::REG_MIN_RUN: begin
          min_run_samples <= wrsd_pkg::MIN_RUN_BITS'(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= sample;
      s1_first  <= clip_first;
      s1_last   <= clip_last;
    end
  end

  wrsd_window #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .first        (s1_first),
    .last         (s1_last),
    .sample       (s1_sample),
    .window_size  (window_size),
    .threshold_sq (threshold_sq),
    .status       (status)
  );

  wrsd_run #(
    .INDEX_BITS (INDEX_BITS)
  ) u_run (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .first           (s1_first),
    .last            (s1_last),
    .status          (status),
    .min_run_samples (min_run_samples),
    .report          (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && report.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && report.valid) begin
      run_start <= report.start;
      run_end   <= report.stop;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word lost from input register");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("stall with empty input register");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step && report.valid))
    else $error("result without a reported run");

endmodule

`default_nettype wire

>>> sim/windowed_rms_silence_detector_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_rms_silence_detector_test
// Self-checking bench for the windowed RMS silence detector.
// ----------------------------------------------------------------------------
// A queue of sample words feeds a falling-edge driver. Every accepted word is
// run through a local model of the window energy and silent-run tracking, and
// the silent runs it reports are queued. Each word the block hands out is
// checked field by field against the oldest queued run. Stimulus covers the
// field extremes, zero and oversize windows, full-scale energy, single-word
// clips and words after a clip end, then random clips with quiet and loud
// stretches under a range of settings, with random stalls on both sides.
module windowed_rms_silence_detector_test;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int WIN_CAP     = 8192;
  localparam int FULL_WORDS  = 64;
  localparam logic [wrsd_pkg::CFG_INDEX_BITS-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic signed [15:0] smp;
    logic               first;
    logic               last;
  } word_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
  } run_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] sample = '0;
  logic clip_first = 1'b0;
  logic clip_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] run_start;
  logic [31:0] run_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wrsd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [wrsd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  windowed_rms_silence_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .clip_first(clip_first), .clip_last(clip_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .run_start(run_start), .run_end(run_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model settings and state
  logic [13:0] win_size = wrsd_pkg::WINDOW_SIZE_RESET;
  logic [30:0] thr_sq   = wrsd_pkg::THRESHOLD_SQ_RESET;
  logic [31:0] min_run  = wrsd_pkg::MIN_RUN_RESET;
  logic [42:0] energy   = '0;
  logic [13:0] win_fill = '0;
  logic [31:0] pos      = '0;
  logic [31:0] win_open = '0;
  logic [31:0] run_open = '0;
  logic        silent   = 1'b0;

  word_t pending_words[$];
  run_t  expected_runs[$];
  word_t drv_word;
  bit    in_taken = 0;
  int    send_pct = 0;
  int    recv_pct = 0;
  bit    hold_req = 0;
  int    hold_left = 0;
  int    errors = 0;
  int    random_words = 0;
  int    cycles = 0;
  int    rand_win = 1;

  task automatic clear_tracking();
    energy = '0;
    win_fill = '0;
    pos = '0;
    win_open = '0;
    run_open = '0;
    silent = 1'b0;
  endtask

  task automatic track_silence(input logic signed [15:0] s, input logic f, input logic l);
    logic [15:0] mag;
    logic [31:0] sq;
    logic [43:0] sum;
    logic [14:0] win;
    logic        quiet_win;
    logic        hit;
    run_t        r;
    hit = 1'b0;
    r = '0;
    if (f) clear_tracking();
    win = (win_size == 0) ? 15'd1 : 15'(win_size);
    if (win > WIN_CAP) win = 15'(WIN_CAP);
    if (win_fill == 0) win_open = pos;
    mag = s[15] ? (~s + 16'd1) : s;
    sq = 32'(mag) * 32'(mag);
    sum = {1'b0, energy} + 44'(sq);
    energy = sum[43] ? '1 : sum[42:0];
    win_fill = win_fill + 14'd1;
    if (pos != '1) pos = pos + 32'd1;
    if (15'(win_fill) >= win || l) begin
      quiet_win = 64'(energy) < 64'(thr_sq) * 64'(win_fill);
      if (quiet_win) begin
        if (!silent) begin
          run_open = win_open;
          silent = 1'b1;
        end
      end else if (silent) begin
        if (win_open - run_open > min_run) begin
          r.start = run_open;
          r.stop = win_open;
          hit = 1'b1;
        end
        silent = 1'b0;
      end
      energy = '0;
      win_fill = '0;
    end
    if (l) begin
      if (silent && pos - run_open > min_run) begin
        r.start = run_open;
        r.stop = pos;
        hit = 1'b1;
      end
      clear_tracking();
    end
    if (hit) expected_runs.insert(expected_runs.size(), r);
  endtask

  // acceptance and result checking
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        track_silence(sample, clip_first, clip_last);
        in_taken = 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_runs.size() == 0) begin
          errors++;
          $display("%0t unexpected word: run_start %0d run_end %0d", $time, run_start, run_end);
        end else begin
          run_t e;
          e = expected_runs.pop_front();
          if (run_start !== e.start) begin
            errors++;
            $display("%0t run_start expected %0d actual %0d", $time, e.start, run_start);
          end
          if (run_end !== e.stop) begin
            errors++;
            $display("%0t run_end expected %0d actual %0d", $time, e.stop, run_end);
          end
        end
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 0;
      if (pending_words.size() != 0 && $urandom_range(99) >= send_pct) begin
        drv_word = pending_words.pop_front();
        in_valid <= 1'b1;
        sample <= drv_word.smp;
        clip_first <= drv_word.first;
        clip_last <= drv_word.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  task automatic push_word(input logic signed [15:0] s, input logic f, input logic l);
    word_t w;
    w.smp = s;
    w.first = f;
    w.last = l;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic wait_quiet();
    while (pending_words.size() != 0 || in_valid || expected_runs.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wrsd_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wrsd_pkg::REG_WINDOW_SIZE:  win_size = val[13:0];
      wrsd_pkg::REG_THRESHOLD_SQ: thr_sq = val[30:0];
      wrsd_pkg::REG_MIN_RUN:      min_run = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic gen_clip();
    int len;
    int seg;
    int k;
    bit quiet;
    bit noisy;
    logic signed [15:0] s;
    logic f;
    logic l;
    len = $urandom_range(1, 60);
    noisy = ($urandom_range(9) == 0);
    k = 0;
    while (k < len) begin
      quiet = 1'($urandom_range(1));
      seg = $urandom_range(1, 3 * rand_win);
      while (seg > 0 && k < len) begin
        if (quiet) begin
          s = 16'($urandom_range(20));
          s = s - 16'sd10;
        end else begin
          s = 16'($urandom);
        end
        f = (k == 0);
        l = (k == len - 1);
        if (noisy) begin
          f = ($urandom_range(7) == 0);
          l = ($urandom_range(7) == 0);
        end
        push_word(s, f, l);
        random_words++;
        seg--;
        k++;
      end
    end
  endtask

  initial begin
    send_pct = 27;
    recv_pct = 46;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, extremes, words after a clip end, one-word clip
    push_word(16'sd0, 1'b1, 1'b0);
    push_word(16'sd32767, 1'b0, 1'b0);
    push_word(-16'sd32768, 1'b0, 1'b1);
    push_word(16'sd1, 1'b0, 1'b0);
    push_word(-16'sd1, 1'b0, 1'b1);
    push_word(16'sd0, 1'b1, 1'b1);
    wait_quiet();

    // zero window acts as one sample
    write_reg(wrsd_pkg::REG_WINDOW_SIZE, 32'd0);
    write_reg(wrsd_pkg::REG_THRESHOLD_SQ, 32'd1000);
    write_reg(wrsd_pkg::REG_MIN_RUN, 32'd0);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    push_word(16'sd0, 1'b1, 1'b0);
    push_word(16'sd0, 1'b0, 1'b0);
    push_word(16'sd200, 1'b0, 1'b0);
    push_word(-16'sd31, 1'b0, 1'b0);
    push_word(-16'sd32, 1'b0, 1'b1);
    push_word(16'sd5, 1'b1, 1'b1);
    push_word(16'sd0, 1'b1, 1'b0);
    push_word(16'sd0, 1'b0, 1'b0);
    push_word(16'sd0, 1'b1, 1'b0);
    push_word(16'sd0, 1'b0, 1'b1);
    wait_quiet();

    // oversize window, zero threshold, largest minimum run
    write_reg(wrsd_pkg::REG_WINDOW_SIZE, 32'hFFFF_FFFF);
    write_reg(wrsd_pkg::REG_THRESHOLD_SQ, 32'd0);
    write_reg(wrsd_pkg::REG_MIN_RUN, 32'hFFFF_FFFF);
    push_word(16'sd0, 1'b1, 1'b0);
    push_word(16'sd0, 1'b0, 1'b1);
    wait_quiet();

    // full-scale samples in a largest window cut short by the clip end
    write_reg(wrsd_pkg::REG_WINDOW_SIZE, 32'd8192);
    write_reg(wrsd_pkg::REG_THRESHOLD_SQ, 32'hC000_0000);
    write_reg(wrsd_pkg::REG_MIN_RUN, 32'd0);
    for (int i = 0; i < FULL_WORDS; i++)
      push_word(-16'sd32768, i == 0, i == FULL_WORDS - 1);
    wait_quiet();

    // receiver holds off while the sender keeps offering
    write_reg(wrsd_pkg::REG_WINDOW_SIZE, 32'd1);
    write_reg(wrsd_pkg::REG_THRESHOLD_SQ, 32'h7FFF_FFFF);
    write_reg(wrsd_pkg::REG_THRESHOLD_SQ, 32'd1000);
    send_pct = 0;
    for (int i = 0; i < 200; i++)
      push_word((i % 2 == 0) ? 16'sd0 : 16'sd20000, i == 0, i == 199);
    hold_req = 1;
    wait_quiet();

    while (random_words < 1100) begin
      if (random_words < 370) begin
        send_pct = 27;
        recv_pct = 46;
      end else if (random_words < 740) begin
        send_pct = 46;
        recv_pct = 27;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      rand_win = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (rand_win == 1 && $urandom_range(1))
        write_reg(wrsd_pkg::REG_WINDOW_SIZE, 32'($urandom) & 32'hFFFF_C000);
      else
        write_reg(wrsd_pkg::REG_WINDOW_SIZE, (32'($urandom) & 32'hFFFF_C000) | rand_win);
      write_reg(wrsd_pkg::REG_THRESHOLD_SQ,
                (32'($urandom) & 32'h8000_0000) | $urandom_range(150, 5000));
      write_reg(wrsd_pkg::REG_MIN_RUN, $urandom_range(0, 12));
      repeat (3) gen_clip();
      wait_quiet();
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_runs.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
design/wrsd_pkg.sv
design/wrsd_window.sv
design/wrsd_run.sv
design/windowed_rms_silence_detector.sv
sim/windowed_rms_silence_detector_test.sv
